// ===== sv/bfuh_pkg.sv =====
// Shared constants and helper functions for the Bloom filter with universal hashing.
package bfuh_pkg;

  localparam int unsigned NumHashes = 8;
  localparam int unsigned HashW     = $clog2(NumHashes);
  localparam int unsigned MaxKeyLen = 64;
  localparam int unsigned PosW      = $clog2(MaxKeyLen + 1);
  localparam int unsigned CoefAw    = $clog2(MaxKeyLen);
  localparam int unsigned TableBits = 65536;
  localparam int unsigned TableAw   = $clog2(TableBits);

  localparam int unsigned CoefW = 21;
  localparam int unsigned SumW  = 28;
  localparam int unsigned RowW  = CoefW * NumHashes;

  localparam logic [CoefW-1:0] HashMod  = 21'd2000003;
  // floor(2^32 / HashMod); the quotient estimate is then low by at most one.
  localparam logic [11:0]      Recip    = 12'd2147;
  localparam logic [31:0]      LfsrMask = 32'hD000_0001;

  typedef logic [CoefW-1:0] coef_t;
  typedef logic [SumW-1:0]  sum_t;

  // One step of the Galois LFSR.
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    lfsr_step = (s >> 1) ^ (s[0] ? LfsrMask : 32'd0);
  endfunction

  // Magnitude of a byte read as a signed char.
  function automatic logic [7:0] byte_mag(input logic [7:0] b);
    byte_mag = b[7] ? (~b + 8'd1) : b;
  endfunction

endpackage

// ===== sv/bfuh_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module bfuh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bloom_filter_universal_hash_top.sv =====
// Bloom filter top level: eight hashes over a byte-serial key, eight bit tables.
//
// A key arrives one byte per request, and a zero byte ends it; only the terminator
// produces a response (insert done, or the query answer). A non-zero byte within the
// length limit is worked through before the next byte is accepted: the acceptance,
// one coefficient row read, then for each of the eight hashes one product and a
// reduction modulo 2000003 (S_M1, S_M2, S_M3) in a single shared reduction unit.
// The first use of a key position first draws its eight coefficients from the LFSR
// through the same unit, in place of the row read. Bytes past the limit only set
// the overflow flag. A terminator passes through S_TERM and S_RESP and may wait for
// the response register. After reset the bit tables are cleared one address per
// cycle in all eight tables at once, while no request is accepted; a seed write
// redraws the eight offsets and forgets all coefficients, but keeps the bit tables.
// No request is accepted in a cycle with a seed write.
module bloom_filter_universal_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  key_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        member_o,
  output logic        key_too_long_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DRAW, S_COEF_RD, S_PROD, S_M1, S_M2, S_M3, S_TERM, S_RESP
  } state_e;

  typedef enum logic [1:0] {JOB_OFFSET, JOB_COEF, JOB_SUM} job_e;

  localparam logic [bfuh_pkg::HashW-1:0] LastHash = bfuh_pkg::HashW'(bfuh_pkg::NumHashes - 1);
  localparam logic [bfuh_pkg::PosW-1:0]  PosLimit = bfuh_pkg::PosW'(bfuh_pkg::MaxKeyLen);
  localparam logic [bfuh_pkg::TableAw-1:0] ClrLast = '1;

  state_e state_q;
  job_e   job_q;
  logic [bfuh_pkg::HashW-1:0] h_q;
  logic [31:0] lfsr_q;
  logic [bfuh_pkg::PosW-1:0] pos_q;
  logic ovf_q;
  logic [bfuh_pkg::MaxKeyLen-1:0] coef_valid_q;
  logic clearing_q;
  logic [bfuh_pkg::TableAw-1:0] clr_cnt_q;
  logic [7:0] mag_q;
  logic cmd_q;

  // Shared reduction unit registers.
  logic [31:0] x_q;
  logic [43:0] prod1_q;
  logic [31:0] qd_q;

  bfuh_pkg::coef_t coef_row_q [bfuh_pkg::NumHashes];
  bfuh_pkg::coef_t offset_q   [bfuh_pkg::NumHashes];
  bfuh_pkg::sum_t  sum_q      [bfuh_pkg::NumHashes];

  logic out_valid_q, kind_q, member_q, too_long_q;

  logic in_accept;
  logic out_free;
  logic [31:0] lfsr_next;
  logic [21:0] r_raw;
  bfuh_pkg::coef_t r_mod;
  logic [bfuh_pkg::RowW-1:0] row_wdata, row_rdata;
  logic coef_we, coef_re;
  logic tbl_we, tbl_re;
  logic [bfuh_pkg::NumHashes-1:0] tbl_rd;

  assign in_stall_o = clearing_q || cfg_we_i || (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign lfsr_next  = bfuh_pkg::lfsr_step(lfsr_q);

  // The estimate x - qe*D lies below twice the modulus, so one correction suffices.
  assign r_raw = x_q[21:0] - qd_q[21:0];
  assign r_mod = (r_raw >= {1'b0, bfuh_pkg::HashMod}) ?
                 bfuh_pkg::CoefW'(r_raw - {1'b0, bfuh_pkg::HashMod}) :
                 bfuh_pkg::CoefW'(r_raw);

  // Coefficient row store: one row of eight coefficients per key position.
  always_comb begin
    for (int g = 0; g < bfuh_pkg::NumHashes; g++) begin
      row_wdata[g*bfuh_pkg::CoefW +: bfuh_pkg::CoefW] =
        (g == int'(LastHash)) ? r_mod : coef_row_q[g];
    end
  end

  assign coef_re = in_accept && (key_byte_i != 8'd0) && (pos_q < PosLimit) &&
                   coef_valid_q[pos_q[bfuh_pkg::CoefAw-1:0]];
  assign coef_we = (state_q == S_M3) && (job_q == JOB_COEF) && (h_q == LastHash);

  bfuh_ram #(
    .Width(bfuh_pkg::RowW),
    .Depth(bfuh_pkg::MaxKeyLen)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .re_i   (coef_re),
    .addr_i (pos_q[bfuh_pkg::CoefAw-1:0]),
    .wdata_i(row_wdata),
    .rdata_o(row_rdata)
  );

  // Bit tables: written with zeros by the clearing pass, with ones by an insert.
  assign tbl_we = clearing_q || ((state_q == S_TERM) && !cmd_q);
  assign tbl_re = (state_q == S_TERM) && cmd_q;

  for (genvar g = 0; g < bfuh_pkg::NumHashes; g++) begin : g_tbl
    logic [bfuh_pkg::TableAw-1:0] addr;
    assign addr = clearing_q ? clr_cnt_q : sum_q[g][bfuh_pkg::TableAw-1:0];
    bfuh_ram #(
      .Width(1),
      .Depth(bfuh_pkg::TableBits)
    ) u_tbl_ram (
      .clk_i  (clk_i),
      .we_i   (tbl_we),
      .re_i   (tbl_re),
      .addr_i (addr),
      .wdata_i(!clearing_q),
      .rdata_o(tbl_rd[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_DRAW;
      job_q        <= JOB_OFFSET;
      h_q          <= '0;
      lfsr_q       <= 32'd1;
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      coef_valid_q <= '0;
      clearing_q   <= 1'b1;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ClrLast) begin
          clearing_q <= 1'b0;
        end
      end

      // Outside a seed write, in the response state the new response takes the register instead.
      if (out_valid_q && !out_stall_i && ((state_q != S_RESP) || cfg_we_i)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        // Reseed: redraw offsets, forget coefficients, drop any partial key.
        lfsr_q       <= (cfg_wdata_i == 32'd0) ? 32'd1 : cfg_wdata_i;
        coef_valid_q <= '0;
        pos_q        <= '0;
        ovf_q        <= 1'b0;
        h_q          <= '0;
        job_q        <= JOB_OFFSET;
        state_q      <= S_DRAW;
      end else begin
        case (state_q)
          S_IDLE: begin
            if (in_accept) begin
              cmd_q <= cmd_i;
              mag_q <= bfuh_pkg::byte_mag(key_byte_i);
              h_q   <= '0;
              if (key_byte_i == 8'd0) begin
                state_q <= S_TERM;
              end else if (pos_q >= PosLimit) begin
                ovf_q <= 1'b1;
              end else if (coef_valid_q[pos_q[bfuh_pkg::CoefAw-1:0]]) begin
                state_q <= S_COEF_RD;
              end else begin
                job_q   <= JOB_COEF;
                state_q <= S_DRAW;
              end
            end
          end
          S_DRAW: begin
            lfsr_q  <= lfsr_next;
            x_q     <= lfsr_next;
            state_q <= S_M1;
          end
          S_COEF_RD: begin
            for (int g = 0; g < bfuh_pkg::NumHashes; g++) begin
              coef_row_q[g] <= row_rdata[g*bfuh_pkg::CoefW +: bfuh_pkg::CoefW];
            end
            job_q   <= JOB_SUM;
            state_q <= S_PROD;
          end
          S_PROD: begin
            x_q     <= 32'(coef_row_q[h_q]) * 32'(mag_q);
            state_q <= S_M1;
          end
          S_M1: begin
            prod1_q <= x_q * bfuh_pkg::Recip;
            state_q <= S_M2;
          end
          S_M2: begin
            qd_q    <= 32'(prod1_q[43:32]) * 32'(bfuh_pkg::HashMod);
            state_q <= S_M3;
          end
          S_M3: begin
            h_q <= h_q + 1'b1;
            case (job_q)
              JOB_OFFSET: begin
                offset_q[h_q] <= r_mod;
                sum_q[h_q]    <= bfuh_pkg::SumW'(r_mod);
                state_q       <= (h_q == LastHash) ? S_IDLE : S_DRAW;
              end
              JOB_COEF: begin
                coef_row_q[h_q] <= r_mod;
                if (h_q == LastHash) begin
                  coef_valid_q[pos_q[bfuh_pkg::CoefAw-1:0]] <= 1'b1;
                  job_q   <= JOB_SUM;
                  state_q <= S_PROD;
                end else begin
                  state_q <= S_DRAW;
                end
              end
              JOB_SUM: begin
                sum_q[h_q] <= sum_q[h_q] + bfuh_pkg::SumW'(r_mod);
                if (h_q == LastHash) begin
                  pos_q   <= pos_q + 1'b1;
                  state_q <= S_IDLE;
                end else begin
                  state_q <= S_PROD;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
          S_TERM: begin
            state_q <= S_RESP;
          end
          S_RESP: begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              kind_q      <= cmd_q;
              member_q    <= cmd_q ? (&tbl_rd) : 1'b1;
              too_long_q  <= ovf_q;
              for (int g = 0; g < bfuh_pkg::NumHashes; g++) begin
                sum_q[g] <= bfuh_pkg::SumW'(offset_q[g]);
              end
              pos_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign member_o       = member_q;
  assign key_too_long_o = too_long_q;

endmodule
